// ===== hw/rtl/rpr_pkg.sv =====
// Shared types and constants for the rotary position rotate unit.
// Used by every module under hw/rtl; depends on nothing else.
package rpr_pkg;

  // Command codes on in_command
  localparam logic CMD_ROTATE = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  // Field widths fixed by the interface
  localparam int unsigned PAIR_W  = 6;
  localparam int unsigned FREQ_W  = 32;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned PHASE_W = 32;

  // Fixed-point trig datapath: angles and squares in Q0.30, accumulators up to one
  localparam int unsigned TH_W  = 30;
  localparam int unsigned ACC_W = 31;
  localparam logic [ACC_W-1:0] Q_ONE = 31'h4000_0000;

  // Two pi in Q3.29, applied to an eighth-turn offset to give radians
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

  // Horner divisors per cell; zero leaves the sine lane untouched in that cell
  localparam int unsigned NUM_CELLS = 6;
  localparam int unsigned SIN_K [NUM_CELLS] = '{0, 110, 72, 42, 20, 6};
  localparam int unsigned COS_K [NUM_CELLS] = '{132, 90, 56, 30, 12, 2};

  // Reset value of query_scale, about one over root 128 in Q0.16
  localparam logic [SCALE_W-1:0] QUERY_SCALE_RESET = 16'd5793;

  // Parameter defaults
  localparam int unsigned MAX_PAIRS_DEF     = 64;
  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned DATA_BITS_DEF     = 16;

  // Word handed along the Horner cells
  typedef struct packed {
    logic [TH_W-1:0]  th;
    logic [TH_W-1:0]  t2;
    logic [ACC_W-1:0] acc_sin;
    logic [ACC_W-1:0] acc_cos;
    logic [1:0]       quad;
    logic             swap;
  } trig_t;

endpackage

// ===== hw/rtl/rotary_position_rotate_unit.sv =====
// Top level of the rotary position rotate unit (NeoX pairing, fixed point).
// Depends on rpr_pkg, rpr_phase_front, rpr_horner_cell and rpr_rotate_back.
//
// Channel  Dir  Handshake            Word
// in_*     in   in_valid/in_ready    command, pair_index, position, is_query,
//                                    first_value, second_value, freq_word
// out_*    out  out_valid/out_ready  first_result, second_result, saturated
// cfg_*    in   cfg_we               query_scale (16 bits, no wait)
//
// One word is taken per cycle while in_ready is high; a rotate word passes through the
// four-stage front, six two-stage Horner cells and the five-stage back.
// A table write is taken but gives no result.
// Each stage moves on when the next one is empty or moving, so input is taken
// while a result waits, until every stage holds a word.
// Synchronous reset clears stage valids and restores query_scale; the table is not cleared.
module rotary_position_rotate_unit #(
  parameter int unsigned MAX_PAIRS     = rpr_pkg::MAX_PAIRS_DEF,
  parameter int unsigned POSITION_BITS = rpr_pkg::POSITION_BITS_DEF,
  parameter int unsigned DATA_BITS     = rpr_pkg::DATA_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic [rpr_pkg::PAIR_W-1:0]    in_pair_index,
  input  logic [POSITION_BITS-1:0]      in_position,
  input  logic                          in_is_query,
  input  logic signed [DATA_BITS-1:0]   in_first_value,
  input  logic signed [DATA_BITS-1:0]   in_second_value,
  input  logic [rpr_pkg::FREQ_W-1:0]    in_freq_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [DATA_BITS-1:0]   out_first_result,
  output logic signed [DATA_BITS-1:0]   out_second_result,
  output logic                          out_saturated,
  input  logic                          cfg_we,
  input  logic [rpr_pkg::SCALE_W-1:0]   cfg_wdata
);

  localparam int unsigned SIDE_W = 2 * DATA_BITS + 1;
  localparam int unsigned NC     = rpr_pkg::NUM_CELLS;

  logic [rpr_pkg::SCALE_W-1:0] query_scale_r;

  logic [NC:0]           valid_link;
  logic [NC:0]           ready_link;
  rpr_pkg::trig_t        trig_link [NC+1];
  logic [SIDE_W-1:0]     side_link [NC+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_scale_r <= rpr_pkg::QUERY_SCALE_RESET;
    end else if (cfg_we) begin
      query_scale_r <= cfg_wdata;
    end
  end

  rpr_phase_front #(
    .MAX_PAIRS     (MAX_PAIRS),
    .POSITION_BITS (POSITION_BITS),
    .DATA_BITS     (DATA_BITS),
    .SIDE_W        (SIDE_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_pair_index   (in_pair_index),
    .in_position     (in_position),
    .in_is_query     (in_is_query),
    .in_first_value  (in_first_value),
    .in_second_value (in_second_value),
    .in_freq_word    (in_freq_word),
    .out_valid       (valid_link[0]),
    .out_ready       (ready_link[0]),
    .out_trig        (trig_link[0]),
    .out_side        (side_link[0])
  );

  for (genvar i = 0; i < NC; i++) begin : g_cell
    rpr_horner_cell #(
      .K_SIN  (rpr_pkg::SIN_K[i]),
      .K_COS  (rpr_pkg::COS_K[i]),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (valid_link[i]),
      .in_ready  (ready_link[i]),
      .in_trig   (trig_link[i]),
      .in_side   (side_link[i]),
      .out_valid (valid_link[i+1]),
      .out_ready (ready_link[i+1]),
      .out_trig  (trig_link[i+1]),
      .out_side  (side_link[i+1])
    );
  end

  rpr_rotate_back #(
    .DATA_BITS (DATA_BITS),
    .SIDE_W    (SIDE_W)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (valid_link[NC]),
    .in_ready          (ready_link[NC]),
    .in_trig           (trig_link[NC]),
    .in_side           (side_link[NC]),
    .query_scale       (query_scale_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_first_result  (out_first_result),
    .out_second_result (out_second_result),
    .out_saturated     (out_saturated)
  );

endmodule

// ===== hw/rtl/rpr_phase_front.sv =====
// Input stage, frequency table, phase and octant reduction, angle and square.
// Depends on rpr_pkg.
module rpr_phase_front #(
  parameter int unsigned MAX_PAIRS     = rpr_pkg::MAX_PAIRS_DEF,
  parameter int unsigned POSITION_BITS = rpr_pkg::POSITION_BITS_DEF,
  parameter int unsigned DATA_BITS     = rpr_pkg::DATA_BITS_DEF,
  parameter int unsigned SIDE_W        = 2 * DATA_BITS + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_command,
  input  logic [rpr_pkg::PAIR_W-1:0]  in_pair_index,
  input  logic [POSITION_BITS-1:0]    in_position,
  input  logic                        in_is_query,
  input  logic signed [DATA_BITS-1:0] in_first_value,
  input  logic signed [DATA_BITS-1:0] in_second_value,
  input  logic [rpr_pkg::FREQ_W-1:0]  in_freq_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rpr_pkg::trig_t              out_trig,
  output logic [SIDE_W-1:0]           out_side
);

  localparam int unsigned ADDR_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

  logic [rpr_pkg::FREQ_W-1:0] freq_mem [MAX_PAIRS];

  logic                 v0_r, v1_r, v2_r, v3_r;
  logic                 rdy0, rdy1, rdy2, rdy3;
  logic                 accept;
  logic                 in_range;
  logic [ADDR_W-1:0]    addr;

  // stage 0: table read
  logic [rpr_pkg::FREQ_W-1:0] rd_r;
  logic                       in_range_r;
  logic [POSITION_BITS-1:0]   pos0_r;
  logic [SIDE_W-1:0]          side0_r;

  // stage 1: phase
  logic [rpr_pkg::FREQ_W-1:0]        freq1;
  logic [POSITION_BITS+31:0]         phase_prod;
  logic [rpr_pkg::PHASE_W-1:0]       phase1_r;
  logic [SIDE_W-1:0]                 side1_r;

  // stage 2: angle
  logic [29:0]                 r_off;
  logic                        swap_nxt;
  logic [rpr_pkg::TH_W-1:0]    y_nxt;
  logic [61:0]                 th_prod;
  logic [rpr_pkg::TH_W-1:0]    th2_r;
  logic [1:0]                  quad2_r;
  logic                        swap2_r;
  logic [SIDE_W-1:0]           side2_r;

  // stage 3: square
  logic [59:0]          sq_prod;
  rpr_pkg::trig_t       trig3_nxt;
  rpr_pkg::trig_t       trig3_r;
  logic [SIDE_W-1:0]    side3_r;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign in_ready = rdy0;
  assign accept   = in_valid && rdy0;

  assign in_range = (32'(in_pair_index) < 32'(MAX_PAIRS));
  assign addr     = ADDR_W'(in_pair_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      // table writes leave no word in the pipe
      if (rdy0) v0_r <= in_valid && (in_command == rpr_pkg::CMD_ROTATE);
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_command == rpr_pkg::CMD_WRITE) && in_range) begin
      freq_mem[addr] <= in_freq_word;
    end
    if (rdy0) begin
      rd_r <= freq_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      in_range_r <= in_range;
      pos0_r     <= in_position;
      side0_r    <= {in_is_query, in_first_value, in_second_value};
    end
  end

  // phase wraps modulo one turn: keep the low 32 bits
  always_comb begin
    freq1      = in_range_r ? rd_r : '0;
    phase_prod = pos0_r * freq1;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      phase1_r <= phase_prod[rpr_pkg::PHASE_W-1:0];
      side1_r  <= side0_r;
    end
  end

  // fold the offset into the first eighth turn; upper half swaps sin and cos
  always_comb begin
    r_off    = phase1_r[29:0];
    swap_nxt = r_off[29];
    y_nxt    = swap_nxt ? rpr_pkg::TH_W'(rpr_pkg::Q_ONE - {1'b0, r_off}) : r_off;
    th_prod  = y_nxt * rpr_pkg::TWO_PI_Q29;
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      th2_r   <= th_prod[60:31];
      quad2_r <= phase1_r[31:30];
      swap2_r <= swap_nxt;
      side2_r <= side1_r;
    end
  end

  always_comb begin
    sq_prod           = th2_r * th2_r;
    trig3_nxt.th      = th2_r;
    trig3_nxt.t2      = sq_prod[59:30];
    trig3_nxt.acc_sin = rpr_pkg::Q_ONE;
    trig3_nxt.acc_cos = rpr_pkg::Q_ONE;
    trig3_nxt.quad    = quad2_r;
    trig3_nxt.swap    = swap2_r;
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      trig3_r <= trig3_nxt;
      side3_r <= side2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_trig  = trig3_r;
  assign out_side  = side3_r;

  a_write_stays_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_command == rpr_pkg::CMD_WRITE)) |=> !v0_r)
    else $error("table write entered the rotate pipe");

endmodule

// ===== hw/rtl/rpr_horner_cell.sv =====
// One Horner step of the sine and cosine series, two register stages deep.
// Depends on rpr_pkg; the divide by K is a reciprocal multiply, exact for 30-bit operands.
module rpr_horner_cell #(
  parameter int unsigned K_SIN  = 110,
  parameter int unsigned K_COS  = 132,
  parameter int unsigned SIDE_W = 33
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rpr_pkg::trig_t    in_trig,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output rpr_pkg::trig_t    out_trig,
  output logic [SIDE_W-1:0] out_side
);

  localparam int unsigned K_LANE [2] = '{K_SIN, K_COS};

  logic                         va_r, vb_r;
  logic                         rdy_a, rdy_b;
  rpr_pkg::trig_t               trig_a_r, trig_b_nxt, trig_b_r;
  logic [SIDE_W-1:0]            side_a_r, side_b_r;
  logic [rpr_pkg::ACC_W-1:0]    acc_in   [2];
  logic [rpr_pkg::ACC_W-1:0]    acc_hold [2];
  logic [rpr_pkg::ACC_W-1:0]    acc_new  [2];

  assign rdy_b    = !vb_r || out_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  assign acc_in[0]   = in_trig.acc_sin;
  assign acc_in[1]   = in_trig.acc_cos;
  assign acc_hold[0] = trig_a_r.acc_sin;
  assign acc_hold[1] = trig_a_r.acc_cos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    if (K_LANE[l] == 0) begin : g_bypass
      assign acc_new[l] = acc_hold[l];
    end else begin : g_step
      // q = floor(n / K) = (n * M) >> SH with M = ceil(2^SH / K), n below 2^30
      localparam int unsigned SH  = 30 + $clog2(K_LANE[l]);
      localparam logic [63:0] M64 =
        ((64'd1 << SH) + 64'(K_LANE[l]) - 64'd1) / 64'(K_LANE[l]);
      localparam logic [31:0] M   = M64[31:0];

      logic [60:0]               mul_a;
      logic [rpr_pkg::TH_W-1:0]  n_r;
      logic [61:0]               mul_b;
      logic [rpr_pkg::ACC_W-1:0] q;

      assign mul_a = in_trig.t2 * acc_in[l];

      always_ff @(posedge clk) begin
        if (rdy_a) n_r <= mul_a[59:30];
      end

      assign mul_b      = n_r * M;
      assign q          = rpr_pkg::ACC_W'(mul_b >> SH);
      assign acc_new[l] = rpr_pkg::Q_ONE - q;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      trig_a_r <= in_trig;
      side_a_r <= in_side;
    end
  end

  always_comb begin
    trig_b_nxt         = trig_a_r;
    trig_b_nxt.acc_sin = acc_new[0];
    trig_b_nxt.acc_cos = acc_new[1];
  end

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      trig_b_r <= trig_b_nxt;
      side_b_r <= side_a_r;
    end
  end

  assign out_valid = vb_r;
  assign out_trig  = trig_b_r;
  assign out_side  = side_b_r;

  a_acc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r |-> ((trig_b_r.acc_sin <= rpr_pkg::Q_ONE) && (trig_b_r.acc_cos <= rpr_pkg::Q_ONE)))
    else $error("Horner accumulator above one");

endmodule

// ===== hw/rtl/rpr_rotate_back.sv =====
// Final sine product, quadrant signs, pair rotation, query scaling, rounding, clipping.
// Depends on rpr_pkg; ends in the output register of the result channel.
module rpr_rotate_back #(
  parameter int unsigned DATA_BITS = rpr_pkg::DATA_BITS_DEF,
  parameter int unsigned SIDE_W    = 2 * DATA_BITS + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rpr_pkg::trig_t                in_trig,
  input  logic [SIDE_W-1:0]             in_side,
  input  logic [rpr_pkg::SCALE_W-1:0]   query_scale,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [DATA_BITS-1:0]   out_first_result,
  output logic signed [DATA_BITS-1:0]   out_second_result,
  output logic                          out_saturated
);

  localparam int unsigned ROT_W = DATA_BITS + 32;
  localparam int unsigned KEY_W = DATA_BITS + 3;
  localparam int unsigned Q16_W = DATA_BITS + 17;
  localparam int unsigned MUL_W = Q16_W + rpr_pkg::SCALE_W + 1;
  localparam int unsigned RND_W = DATA_BITS + 35;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic signed [RND_W-1:0] SAT_HI =
    $signed({{(RND_W-DATA_BITS+1){1'b0}}, {(DATA_BITS-1){1'b1}}});
  localparam logic signed [RND_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [DATA_BITS-1:0] OUT_HI = SAT_HI[DATA_BITS-1:0];
  localparam logic signed [DATA_BITS-1:0] OUT_LO = SAT_LO[DATA_BITS-1:0];

  // round half away from zero, then drop sh bits
  function automatic logic signed [RND_W-1:0] round_away(
    input logic signed [RND_W-1:0] v,
    input int unsigned             sh
  );
    logic [RND_W-1:0] mag;
    logic [RND_W-1:0] half;
    half = RND_W'(1) << (sh - 1);
    mag  = v[RND_W-1] ? $unsigned(-v) : $unsigned(v);
    mag  = (mag + half) >> sh;
    return v[RND_W-1] ? -$signed(mag) : $signed(mag);
  endfunction

  logic v0_r, v1_r, v2_r, v3_r, v4_r;
  logic rdy0, rdy1, rdy2, rdy3, rdy4;

  // stage 0: sine product
  logic [60:0]                 sin_prod;
  logic [rpr_pkg::TH_W-1:0]    sin0_r;
  logic [rpr_pkg::ACC_W-1:0]   cos0_r;
  logic [1:0]                  quad0_r;
  logic                        swap0_r;
  logic [SIDE_W-1:0]           side0_r;

  // stage 1: signed sin/cos and the four products
  logic [rpr_pkg::ACC_W-1:0]      s_mag, c_mag;
  logic signed [31:0]             s_pos, c_pos, sn, cs;
  logic signed [DATA_BITS-1:0]    x0, x1;
  logic signed [ROT_W-1:0]        p00_r, p11_r, p01_r, p10_r;
  logic                           query1_r;

  // stage 2: sums and rounding
  logic signed [ROT_W-1:0]        rot0, rot1;
  logic signed [KEY_W-1:0]        key0_r, key1_r;
  logic signed [Q16_W-1:0]        q16_0_r, q16_1_r;
  logic                           query2_r;

  // stage 3: query scaling
  logic signed [rpr_pkg::SCALE_W:0] scale_s;
  logic signed [MUL_W-1:0]          m0_r, m1_r;
  logic signed [KEY_W-1:0]          key0_3_r, key1_3_r;
  logic                             query3_r;

  // stage 4: final rounding and clipping
  logic signed [RND_W-1:0]        sel0, sel1;
  logic signed [DATA_BITS-1:0]    res0_nxt, res1_nxt;
  logic                           sat_nxt;
  logic signed [DATA_BITS-1:0]    res0_r, res1_r;
  logic                           sat_r;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign in_ready = rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  assign sin_prod = in_trig.th * in_trig.acc_sin;

  always_ff @(posedge clk) begin
    if (rdy0) begin
      sin0_r  <= sin_prod[59:30];
      cos0_r  <= in_trig.acc_cos;
      quad0_r <= in_trig.quad;
      swap0_r <= in_trig.swap;
      side0_r <= in_side;
    end
  end

  always_comb begin
    s_mag = swap0_r ? cos0_r : {1'b0, sin0_r};
    c_mag = swap0_r ? {1'b0, sin0_r} : cos0_r;
    s_pos = $signed({1'b0, s_mag});
    c_pos = $signed({1'b0, c_mag});
    unique case (quad0_r)
      QUAD_0: begin
        sn = s_pos;
        cs = c_pos;
      end
      QUAD_1: begin
        sn = c_pos;
        cs = -s_pos;
      end
      QUAD_2: begin
        sn = -s_pos;
        cs = -c_pos;
      end
      QUAD_3: begin
        sn = -c_pos;
        cs = s_pos;
      end
      default: begin
        sn = s_pos;
        cs = c_pos;
      end
    endcase
    x0 = $signed(side0_r[2*DATA_BITS-1:DATA_BITS]);
    x1 = $signed(side0_r[DATA_BITS-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      p00_r    <= x0 * cs;
      p11_r    <= x1 * sn;
      p01_r    <= x0 * sn;
      p10_r    <= x1 * cs;
      query1_r <= side0_r[2*DATA_BITS];
    end
  end

  always_comb begin
    rot0 = p00_r - p11_r;
    rot1 = p01_r + p10_r;
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      key0_r   <= KEY_W'(round_away(RND_W'(rot0), 30));
      key1_r   <= KEY_W'(round_away(RND_W'(rot1), 30));
      q16_0_r  <= Q16_W'(round_away(RND_W'(rot0), 16));
      q16_1_r  <= Q16_W'(round_away(RND_W'(rot1), 16));
      query2_r <= query1_r;
    end
  end

  assign scale_s = $signed({1'b0, query_scale});

  always_ff @(posedge clk) begin
    if (rdy3) begin
      m0_r     <= q16_0_r * scale_s;
      m1_r     <= q16_1_r * scale_s;
      key0_3_r <= key0_r;
      key1_3_r <= key1_r;
      query3_r <= query2_r;
    end
  end

  always_comb begin
    sel0    = query3_r ? round_away(RND_W'(m0_r), 30) : RND_W'(key0_3_r);
    sel1    = query3_r ? round_away(RND_W'(m1_r), 30) : RND_W'(key1_3_r);
    sat_nxt = 1'b0;
    res0_nxt = DATA_BITS'(sel0);
    res1_nxt = DATA_BITS'(sel1);
    // clip to the signed result range and flag it
    if (sel0 > SAT_HI) begin
      res0_nxt = OUT_HI;
      sat_nxt  = 1'b1;
    end else if (sel0 < SAT_LO) begin
      res0_nxt = OUT_LO;
      sat_nxt  = 1'b1;
    end
    if (sel1 > SAT_HI) begin
      res1_nxt = OUT_HI;
      sat_nxt  = 1'b1;
    end else if (sel1 < SAT_LO) begin
      res1_nxt = OUT_LO;
      sat_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      res0_r <= res0_nxt;
      res1_r <= res1_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign out_valid         = v4_r;
  assign out_first_result  = res0_r;
  assign out_second_result = res1_r;
  assign out_saturated     = sat_r;

  a_sat_means_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && sat_r) |-> ((res0_r == OUT_HI) || (res0_r == OUT_LO) ||
                         (res1_r == OUT_HI) || (res1_r == OUT_LO)))
    else $error("saturated flag set on an unclipped word");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !out_ready && v3_r) |=> (v4_r && v3_r))
    else $error("stalled output stage lost a word");

endmodule

// ===== tb/sv/rpr_rotation_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the rotary position rotate unit: mirrors the frequency table and the
// query scale, predicts every rotated word and checks the result channel in order.
// Depends on rpr_pkg.
module rpr_rotation_checker (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  input  logic                                      in_ready,
  input  logic                                      in_command,
  input  logic [rpr_pkg::PAIR_W-1:0]                in_pair_index,
  input  logic [rpr_pkg::POSITION_BITS_DEF-1:0]     in_position,
  input  logic                                      in_is_query,
  input  logic signed [rpr_pkg::DATA_BITS_DEF-1:0]  in_first_value,
  input  logic signed [rpr_pkg::DATA_BITS_DEF-1:0]  in_second_value,
  input  logic [rpr_pkg::FREQ_W-1:0]                in_freq_word,
  input  logic                                      out_valid,
  input  logic                                      out_ready,
  input  logic signed [rpr_pkg::DATA_BITS_DEF-1:0]  out_first_result,
  input  logic signed [rpr_pkg::DATA_BITS_DEF-1:0]  out_second_result,
  input  logic                                      out_saturated,
  input  logic                                      cfg_we,
  input  logic [rpr_pkg::SCALE_W-1:0]               cfg_wdata,
  output int                                        fail_count,
  output int                                        pending,
  output int                                        results_seen,
  output int                                        clipped_seen
);

  localparam int unsigned DW = rpr_pkg::DATA_BITS_DEF;
  localparam longint WORD_MAX = (longint'(1) << (DW - 1)) - 1;
  localparam longint WORD_MIN = -WORD_MAX - 1;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned EIGHTH_TURN = 64'd1 << 29;

  typedef struct packed {
    logic signed [DW-1:0] first;
    logic signed [DW-1:0] second;
    logic                 clipped;
  } rotated_word_t;

  rotated_word_t               expected_q[$];
  rotated_word_t               want;
  logic [rpr_pkg::FREQ_W-1:0]  freq_mirror [rpr_pkg::MAX_PAIRS_DEF];
  logic [rpr_pkg::SCALE_W-1:0] scale_mirror = rpr_pkg::QUERY_SCALE_RESET;
  int                          fails = 0;
  int                          seen = 0;
  int                          clipped = 0;

  function automatic longint unsigned taylor_step(longint unsigned t2, longint unsigned acc,
                                                  longint unsigned k);
    return ONE_Q30 - ((t2 * acc) >> 30) / k;
  endfunction

  // Offset is Q0.32 turns within one eighth; results are Q2.30
  function automatic longint unsigned sine_of_eighth(longint unsigned offset);
    longint unsigned th, t2, acc;
    th = (offset * longint'(rpr_pkg::TWO_PI_Q29)) >> 31;
    t2 = (th * th) >> 30;
    acc = ONE_Q30;
    acc = taylor_step(t2, acc, 110);
    acc = taylor_step(t2, acc, 72);
    acc = taylor_step(t2, acc, 42);
    acc = taylor_step(t2, acc, 20);
    acc = taylor_step(t2, acc, 6);
    return (th * acc) >> 30;
  endfunction

  function automatic longint unsigned cosine_of_eighth(longint unsigned offset);
    longint unsigned th, t2, acc;
    th = (offset * longint'(rpr_pkg::TWO_PI_Q29)) >> 31;
    t2 = (th * th) >> 30;
    acc = ONE_Q30;
    acc = taylor_step(t2, acc, 132);
    acc = taylor_step(t2, acc, 90);
    acc = taylor_step(t2, acc, 56);
    acc = taylor_step(t2, acc, 30);
    acc = taylor_step(t2, acc, 12);
    acc = taylor_step(t2, acc, 2);
    return acc;
  endfunction

  function automatic longint round_half_away(longint v, int unsigned sh);
    longint unsigned mag;
    mag = (v < 0) ? longint'(-v) : v;
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint scaled_result(longint v, logic query,
                                           logic [rpr_pkg::SCALE_W-1:0] scale);
    if (query)
      return round_half_away(round_half_away(v, 16) * longint'({48'd0, scale}), 30);
    return round_half_away(v, 30);
  endfunction

  function automatic longint clip_word(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic rotated_word_t predict_rotation(
      logic [rpr_pkg::POSITION_BITS_DEF-1:0] pos, logic [rpr_pkg::FREQ_W-1:0] freq,
      logic query, logic signed [DW-1:0] a, logic signed [DW-1:0] b,
      logic [rpr_pkg::SCALE_W-1:0] scale);
    logic [rpr_pkg::PHASE_W-1:0] phase;
    longint unsigned             offset, sv, cv;
    longint                      sn, cs, r0, r1, c0, c1;
    rotated_word_t               res;
    phase = rpr_pkg::PHASE_W'(64'(pos) * 64'(freq));
    offset = phase[29:0];
    // past the eighth, fold back and swap sine with cosine
    if (offset < EIGHTH_TURN) begin
      sv = sine_of_eighth(offset);
      cv = cosine_of_eighth(offset);
    end else begin
      sv = cosine_of_eighth(ONE_Q30 - offset);
      cv = sine_of_eighth(ONE_Q30 - offset);
    end
    case (phase[31:30])
      2'b00: begin sn = sv;  cs = cv;  end
      2'b01: begin sn = cv;  cs = -sv; end
      2'b10: begin sn = -sv; cs = -cv; end
      default: begin sn = -cv; cs = sv; end
    endcase
    r0 = scaled_result(longint'(a) * cs - longint'(b) * sn, query, scale);
    r1 = scaled_result(longint'(a) * sn + longint'(b) * cs, query, scale);
    c0 = clip_word(r0);
    c1 = clip_word(r1);
    res.first = c0[DW-1:0];
    res.second = c1[DW-1:0];
    res.clipped = (c0 != r0) || (c1 != r1);
    return res;
  endfunction

  task automatic check_field(input string field, input logic signed [63:0] want_v,
                             input logic signed [63:0] got_v);
    if (want_v !== got_v) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      // the table survives reset, the scale does not
      expected_q.delete();
      scale_mirror = rpr_pkg::QUERY_SCALE_RESET;
    end else begin
      if (out_valid && out_ready) begin
        seen++;
        if (out_saturated === 1'b1) clipped++;
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: result word with none expected, expected nothing, got %0d %0d %0b",
                   $time, out_first_result, out_second_result, out_saturated);
        end else begin
          want = expected_q.pop_front();
          check_field("first_result", want.first, out_first_result);
          check_field("second_result", want.second, out_second_result);
          check_field("saturated", want.clipped, out_saturated);
        end
      end
      if (in_valid && in_ready) begin
        if (in_command == rpr_pkg::CMD_WRITE)
          freq_mirror[in_pair_index] = in_freq_word;
        else
          expected_q.push_back(predict_rotation(in_position, freq_mirror[in_pair_index],
                                                in_is_query, in_first_value,
                                                in_second_value, scale_mirror));
      end
      if (cfg_we) scale_mirror = cfg_wdata;
    end
    fail_count <= fails;
    pending <= expected_q.size();
    results_seen <= seen;
    clipped_seen <= clipped;
  end

endmodule

// ===== tb/sv/rotary_position_rotate_unit_tb.sv =====
`timescale 1ns / 1ps
// Top of the rotary position rotate unit testbench: clock, reset, stimulus and verdict.
// Depends on rpr_pkg, rotary_position_rotate_unit and rpr_rotation_checker.
module rotary_position_rotate_unit_tb;

  localparam int unsigned DW = rpr_pkg::DATA_BITS_DEF;
  localparam int unsigned PW = rpr_pkg::POSITION_BITS_DEF;
  localparam int unsigned IW = rpr_pkg::PAIR_W;
  localparam int unsigned FW = rpr_pkg::FREQ_W;
  localparam int unsigned SW = rpr_pkg::SCALE_W;
  localparam logic [DW-1:0] VAL_MIN = {1'b1, {(DW - 1){1'b0}}};
  localparam logic [DW-1:0] VAL_MAX = {1'b0, {(DW - 1){1'b1}}};
  localparam int RANDOM_PER_PHASE = 610;
  localparam int SETTLE_CYCLES = 32;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_command;
  logic [IW-1:0]          in_pair_index;
  logic [PW-1:0]          in_position;
  logic                   in_is_query;
  logic signed [DW-1:0]   in_first_value;
  logic signed [DW-1:0]   in_second_value;
  logic [FW-1:0]          in_freq_word;
  logic                   out_valid;
  logic                   out_ready;
  logic signed [DW-1:0]   out_first_result;
  logic signed [DW-1:0]   out_second_result;
  logic                   out_saturated;
  logic                   cfg_we;
  logic [SW-1:0]          cfg_wdata;

  int fail_count;
  int pending;
  int results_seen;
  int clipped_seen;

  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        stall_cycles = 0;
  int        writes_sent = 0;
  int        rotates_sent = 0;
  int        queries_sent = 0;
  bit [63:0] loaded = '0;

  rotary_position_rotate_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_pair_index     (in_pair_index),
    .in_position       (in_position),
    .in_is_query       (in_is_query),
    .in_first_value    (in_first_value),
    .in_second_value   (in_second_value),
    .in_freq_word      (in_freq_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_first_result  (out_first_result),
    .out_second_result (out_second_result),
    .out_saturated     (out_saturated),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  rpr_rotation_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_pair_index     (in_pair_index),
    .in_position       (in_position),
    .in_is_query       (in_is_query),
    .in_first_value    (in_first_value),
    .in_second_value   (in_second_value),
    .in_freq_word      (in_freq_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_first_result  (out_first_result),
    .out_second_result (out_second_result),
    .out_saturated     (out_saturated),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .fail_count        (fail_count),
    .pending           (pending),
    .results_seen      (results_seen),
    .clipped_seen      (clipped_seen)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Receiver: stall at random in the share set by the current phase
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Count cycles in which no word moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("rotary_position_rotate_unit_tb: FAIL");
        $finish;
      end
    end
  end

  // Hold the word until the block takes it; idle before it at random
  task automatic send_word(input logic cmd, input logic [IW-1:0] idx,
                           input logic [PW-1:0] pos, input logic query,
                           input logic [DW-1:0] a, input logic [DW-1:0] b,
                           input logic [FW-1:0] freq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_pair_index <= idx;
    in_position <= pos;
    in_is_query <= query;
    in_first_value <= a;
    in_second_value <= b;
    in_freq_word <= freq;
    do @(posedge clk); while (!in_ready);
    if (cmd == rpr_pkg::CMD_WRITE) begin
      loaded[idx] = 1'b1;
      writes_sent++;
    end else begin
      rotates_sent++;
      if (query) queries_sent++;
    end
  endtask

  task automatic load_freq(input logic [IW-1:0] idx, input logic [FW-1:0] freq);
    send_word(rpr_pkg::CMD_WRITE, idx, PW'($urandom), 1'($urandom), DW'($urandom),
              DW'($urandom), freq);
  endtask

  task automatic rotate_pair(input logic [IW-1:0] idx, input logic [PW-1:0] pos,
                             input logic query, input logic [DW-1:0] a,
                             input logic [DW-1:0] b);
    send_word(rpr_pkg::CMD_ROTATE, idx, pos, query, a, b, $urandom);
  endtask

  // Drop valid, wait for every result, then let any trailing table write finish
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_query_scale(input logic [SW-1:0] value);
    wait_drained();
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [DW-1:0] pick_value();
    case ($urandom_range(7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      default: return DW'($urandom);
    endcase
  endfunction

  task automatic random_item();
    logic [IW-1:0] idx;
    logic [FW-1:0] freq;
    logic [PW-1:0] pos;
    if ($urandom_range(99) < 15) begin
      // real frequencies are mostly small, so shift some down
      freq = $urandom;
      if ($urandom_range(2) == 0) freq = freq >> $urandom_range(31);
      load_freq(IW'($urandom_range(63)), freq);
    end else begin
      // rotate only entries already loaded
      do idx = IW'($urandom_range(63)); while (!loaded[idx]);
      case ($urandom_range(7))
        0: pos = '0;
        1: pos = '1;
        default: pos = PW'($urandom);
      endcase
      rotate_pair(idx, pos, 1'($urandom), pick_value(), pick_value());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = rpr_pkg::CMD_ROTATE;
    in_pair_index = '0;
    in_position = '0;
    in_is_query = 1'b0;
    in_first_value = '0;
    in_second_value = '0;
    in_freq_word = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    send_idle_pct = 16;
    recv_idle_pct = 69;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset scale: zero phase, the eighth boundary, all
    // four quadrants, all but the third also with the fold, full-scale pairs that clip
    load_freq(6'd0, 32'h0000_0000);
    load_freq(6'd63, 32'hFFFF_FFFF);
    load_freq(6'd1, 32'h2000_0000);
    load_freq(6'd2, 32'h4000_0000);
    load_freq(6'd3, 32'hF000_0000);
    load_freq(6'd4, 32'h1FFF_FFFF);
    rotate_pair(6'd0, '1, 1'b0, VAL_MAX, VAL_MIN);
    rotate_pair(6'd1, 16'd1, 1'b0, VAL_MAX, VAL_MIN);
    rotate_pair(6'd1, 16'd1, 1'b1, VAL_MAX, VAL_MIN);
    rotate_pair(6'd1, 16'd3, 1'b0, VAL_MIN, VAL_MIN);
    rotate_pair(6'd2, 16'd1, 1'b0, VAL_MIN, VAL_MAX);
    rotate_pair(6'd2, 16'd3, 1'b1, 16'h4000, 16'hC000);
    rotate_pair(6'd2, 16'd2, 1'b0, 16'h1234, 16'hEDCC);
    rotate_pair(6'd3, 16'd1, 1'b0, VAL_MAX, VAL_MAX);
    rotate_pair(6'd4, 16'd1, 1'b0, VAL_MIN, VAL_MIN);
    rotate_pair(6'd4, 16'd2, 1'b1, '0, '0);
    rotate_pair(6'd63, '1, 1'b1, VAL_MAX, VAL_MIN);
    rotate_pair(6'd63, '0, 1'b0, VAL_MIN, VAL_MAX);
    // overwrite an entry and use it straight away
    load_freq(6'd0, 32'h0001_0000);
    rotate_pair(6'd0, '1, 1'b0, 16'h3039, 16'hE57B);

    // Random phases: scale at full, at zero, then anywhere; idling as the phase asks
    set_query_scale('1);
    repeat (RANDOM_PER_PHASE) random_item();

    send_idle_pct = 69;
    recv_idle_pct = 16;
    set_query_scale('0);
    repeat (RANDOM_PER_PHASE) random_item();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_query_scale(SW'($urandom_range(65535)));
    repeat (RANDOM_PER_PHASE) random_item();

    wait_drained();
    $display("covered %0d table writes and %0d rotations (%0d query) over four scale settings",
             writes_sent, rotates_sent, queries_sent);
    $display("checked %0d result words, %0d saturated, under three stall patterns",
             results_seen, clipped_seen);
    if (fail_count == 0) begin
      $display("rotary_position_rotate_unit_tb: PASS");
    end else begin
      $display("rotary_position_rotate_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rpr_pkg.sv
hw/rtl/rpr_phase_front.sv
hw/rtl/rpr_horner_cell.sv
hw/rtl/rpr_rotate_back.sv
hw/rtl/rotary_position_rotate_unit.sv
tb/sv/rpr_rotation_checker.sv
tb/sv/rotary_position_rotate_unit_tb.sv
